### src/plda_pkg.sv
// shared constants and types for the point light diffuse attenuation block
package plda_pkg;

    localparam int LEVEL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LIGHT_W    = 16;

    // quotient bits in the divider: one above the level width for saturation
    localparam int QUOT_W     = LEVEL_W + 1;

    // S is scaled by 2^16 before the square root, and 1.0 in Q16.16 is 2^16
    localparam int SQRT_SHIFT = 16;
    localparam int ATTEN_ONE  = 65536;
    // numerator scale that aligns the quotient to Q8.8
    localparam int NUM_SHIFT  = 10;

    localparam logic [LEVEL_W-1:0]    STRENGTH_RESET = 16'd256;
    localparam logic [LEVEL_W-1:0]    RADIUS_RESET   = 16'hFFFF;
    localparam logic [2*LEVEL_W-1:0]  RAD_SQ_RESET   =
        (2*LEVEL_W)'(RADIUS_RESET) * (2*LEVEL_W)'(RADIUS_RESET);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_POS_X    = 3'd0,
        REG_LIGHT_POS_Y    = 3'd1,
        REG_LIGHT_POS_Z    = 3'd2,
        REG_LIGHT_STRENGTH = 3'd3,
        REG_REACH_RADIUS   = 3'd4
    } reg_index_t;

endpackage

### src/plda_if.sv
// channel interfaces: vertex input, light level output, configuration writes
interface plda_vertex_if #(
    parameter int COORD_BITS  = 16,
    parameter int NORMAL_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  vertex_x;
    logic signed [COORD_BITS-1:0]  vertex_y;
    logic signed [COORD_BITS-1:0]  vertex_z;
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface plda_level_if;
    logic                           valid;
    logic                           ready;
    logic [plda_pkg::LEVEL_W-1:0]   light_level;
    logic                           beyond_radius;

    modport source (output valid, light_level, beyond_radius, input ready);
    modport sink   (input valid, light_level, beyond_radius, output ready);
endinterface

interface plda_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [plda_pkg::CFG_IDX_W-1:0]   addr;
    logic [plda_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

### src/point_light_diffuse_attenuate.sv
// point light lambert diffuse shading with distance attenuation, top level
//
//  channel   dir  payload                                    handshake
//  cfg       in   addr, wdata (register write)               valid/ready, ready tied high
//  vertex    in   vertex_x/y/z, normal_x/y/z                 valid/ready
//  level     out  light_level, beyond_radius                 valid/ready
//
// one vertex transaction per cycle sustained while the output is not stalled; with
// CW = max(COORD_BITS, 16), there are three front stages, CW + 10 square root stages
// (one root bit each), one multiply stage, 18 divider stages and the output register
// the whole pipeline advances as one; a stalled output holds every stage and
// deasserts vertex.ready in the same cycle
// reset clears the valid bits and loads the register defaults
module point_light_diffuse_attenuate #(
    parameter int COORD_BITS  = 16,
    parameter int NORMAL_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    plda_cfg_if.sink      cfg,
    plda_vertex_if.sink   vertex,
    plda_level_if.source  level
);
    localparam int LW   = plda_pkg::LEVEL_W;
    localparam int HW   = plda_pkg::LIGHT_W;
    localparam int CW   = (COORD_BITS > HW) ? COORD_BITS : HW;
    localparam int DW   = CW + 1;              // light minus vertex
    localparam int SQW  = 2 * DW;              // one squared component
    localparam int SW   = SQW + 2;             // squared length
    localparam int PW   = NORMAL_BITS + DW;    // one normal product
    localparam int DOTW = PW + 2;              // n.d
    localparam int XW   = SW + plda_pkg::SQRT_SHIFT;
    localparam int RW   = XW / 2;              // root width
    localparam int SBW  = SW + DOTW;
    localparam int MW   = DOTW - 1 + LW;
    localparam int NUMW = MW + plda_pkg::NUM_SHIFT;
    localparam int ATW  = SW + 1;
    localparam int DENW = RW + ATW;
    localparam int QB   = plda_pkg::QUOT_W;

    // pipeline advances when the output register is free or being taken
    logic en;

    // configuration registers; the radius is kept squared for the range test
    logic signed [HW-1:0]   lpx_reg, lpy_reg, lpz_reg;
    logic [LW-1:0]          strength_reg;
    logic [2*LW-1:0]        rad_sq_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpx_reg      <= '0;
            lpy_reg      <= '0;
            lpz_reg      <= '0;
            strength_reg <= plda_pkg::STRENGTH_RESET;
            rad_sq_reg   <= plda_pkg::RAD_SQ_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                plda_pkg::REG_LIGHT_POS_X:    lpx_reg      <= cfg.wdata;
                plda_pkg::REG_LIGHT_POS_Y:    lpy_reg      <= cfg.wdata;
                plda_pkg::REG_LIGHT_POS_Z:    lpz_reg      <= cfg.wdata;
                plda_pkg::REG_LIGHT_STRENGTH: strength_reg <= cfg.wdata;
                plda_pkg::REG_REACH_RADIUS:
                    rad_sq_reg <= (2*LW)'(cfg.wdata) * (2*LW)'(cfg.wdata);
                default: ;
            endcase
        end
    end

    // stage 1: vector from vertex to light, normal captured
    logic                          v1_reg;
    logic signed [DW-1:0]          dx_reg, dy_reg, dz_reg;
    logic signed [NORMAL_BITS-1:0] nx_reg, ny_reg, nz_reg;

    // stage 2: squared components and normal products
    logic                   v2_reg;
    logic [SQW-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic signed [PW-1:0]   px_reg, py_reg, pz_reg;

    // stage 3: squared length and dot product
    logic                   v3_reg;
    logic [SW-1:0]          s3_reg;
    logic signed [DOTW-1:0] dot3_reg;

    logic [DW-1:0]  ax, ay, az;

    always_comb
    begin
        ax = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ay = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        az = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vertex.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= {{(DW-HW){lpx_reg[HW-1]}}, lpx_reg}
                    - {{(DW-COORD_BITS){vertex.vertex_x[COORD_BITS-1]}}, vertex.vertex_x};
            dy_reg <= {{(DW-HW){lpy_reg[HW-1]}}, lpy_reg}
                    - {{(DW-COORD_BITS){vertex.vertex_y[COORD_BITS-1]}}, vertex.vertex_y};
            dz_reg <= {{(DW-HW){lpz_reg[HW-1]}}, lpz_reg}
                    - {{(DW-COORD_BITS){vertex.vertex_z[COORD_BITS-1]}}, vertex.vertex_z};
            nx_reg <= vertex.normal_x;
            ny_reg <= vertex.normal_y;
            nz_reg <= vertex.normal_z;

            sqx_reg <= SQW'(ax) * SQW'(ax);
            sqy_reg <= SQW'(ay) * SQW'(ay);
            sqz_reg <= SQW'(az) * SQW'(az);
            px_reg  <= PW'(nx_reg) * PW'(dx_reg);
            py_reg  <= PW'(ny_reg) * PW'(dy_reg);
            pz_reg  <= PW'(nz_reg) * PW'(dz_reg);

            s3_reg   <= SW'(sqx_reg) + SW'(sqy_reg) + SW'(sqz_reg);
            dot3_reg <= DOTW'(px_reg) + DOTW'(py_reg) + DOTW'(pz_reg);
        end
    end

    // length in Q8.16: floor(sqrt(S * 2^16)), squared length and dot ride along
    logic            sq_vld;
    logic [RW-1:0]   sq_root;
    logic [SBW-1:0]  sq_sb;

    plda_sqrt #(
        .XW  (XW),
        .SBW (SBW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .in_x     ({s3_reg, {plda_pkg::SQRT_SHIFT{1'b0}}}),
        .in_sb    ({s3_reg, dot3_reg}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_sb   (sq_sb)
    );

    // multiply stage: numerator dot*strength*1024, denominator r*(1+S)
    logic [SW-1:0]          sm;
    logic signed [DOTW-1:0] dotm;
    logic [MW-1:0]          nprod;
    logic [ATW-1:0]         atten;

    always_comb
    begin
        sm    = sq_sb[SBW-1:DOTW];
        dotm  = sq_sb[DOTW-1:0];
        nprod = MW'(dotm[DOTW-2:0]) * MW'(strength_reg);
        atten = ATW'(sm) + ATW'(plda_pkg::ATTEN_ONE);
    end

    logic              vm_reg;
    logic [NUMW-1:0]   num_reg;
    logic [DENW-1:0]   den_reg;
    logic              beyond_m_reg;
    logic              skip_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg      <= {nprod, {plda_pkg::NUM_SHIFT{1'b0}}};
            den_reg      <= DENW'(sq_root) * DENW'(atten);
            beyond_m_reg <= (sm > SW'(rad_sq_reg));
            // vertex on the light, or surface facing away
            skip_m_reg   <= (sm == '0) || dotm[DOTW-1] || (dotm == '0);
        end
    end

    logic            dv_vld;
    logic [QB-1:0]   dv_q;
    logic            dv_sat;
    logic [1:0]      dv_sb;

    plda_div #(
        .NUMW (NUMW),
        .DENW (DENW),
        .SBW  (2)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vm_reg),
        .in_num  (num_reg),
        .in_den  (den_reg),
        .in_sb   ({beyond_m_reg, skip_m_reg}),
        .out_vld (dv_vld),
        .out_q   (dv_q),
        .out_sat (dv_sat),
        .out_sb  (dv_sb)
    );

    // output register: zero outside the radius or when skipped, clamp at strength
    logic            out_vld_reg;
    logic [LW-1:0]   out_level_reg;
    logic            out_beyond_reg;
    logic [LW-1:0]   level_next;

    always_comb
    begin
        if (dv_sb[1] || dv_sb[0])
            level_next = '0;
        else if (dv_sat || (dv_q > QB'(strength_reg)))
            level_next = strength_reg;
        else
            level_next = dv_q[LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_level_reg  <= level_next;
            out_beyond_reg <= dv_sb[1];
        end
    end

    assign en                  = !out_vld_reg || level.ready;
    assign vertex.ready        = en;
    assign level.valid         = out_vld_reg;
    assign level.light_level   = out_level_reg;
    assign level.beyond_radius = out_beyond_reg;

    // a vertex outside the radius never carries light
    a_beyond_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (level.valid && level.beyond_radius) |-> (level.light_level == '0))
        else $error("light level nonzero outside radius");

    // the result never exceeds the configured strength
    a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        level.valid |-> (level.light_level <= strength_reg))
        else $error("light level above strength");

    // an output stall blocks the input side in the same cycle
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (level.valid && !level.ready) |-> !vertex.ready)
        else $error("input accepted during output stall");

    // a held output transaction keeps its payload
    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (level.valid && !level.ready) |=> ($stable(out_level_reg) && $stable(out_beyond_reg)))
        else $error("stalled result changed");
endmodule

### src/plda_sqrt.sv
// pipelined integer square root, one root bit per stage
module plda_sqrt #(
    parameter int XW  = 52,
    parameter int SBW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [XW-1:0]       in_x,
    input  logic [SBW-1:0]      in_sb,
    output logic                out_vld,
    output logic [XW/2-1:0]     out_root,
    output logic [SBW-1:0]      out_sb
);
    localparam int RW   = XW / 2;
    localparam int REMW = RW + 3;

    logic              vld_reg  [RW];
    logic [REMW-1:0]   rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [XW-1:0]     x_reg    [RW];
    logic [SBW-1:0]    sb_reg   [RW];

    logic              vld_next  [RW];
    logic [REMW-1:0]   rem_next  [RW];
    logic [RW-1:0]     root_next [RW];
    logic [XW-1:0]     x_next    [RW];
    logic [SBW-1:0]    sb_next   [RW];

    always_comb
    begin
        logic [REMW-1:0] prev_rem;
        logic [RW-1:0]   prev_root;
        logic [REMW-1:0] sh;
        logic [REMW-1:0] trial;
        for (int k = 0; k < RW; k++)
        begin
            prev_rem    = (k == 0) ? '0 : rem_reg[k-1];
            prev_root   = (k == 0) ? '0 : root_reg[k-1];
            x_next[k]   = (k == 0) ? in_x : x_reg[k-1];
            sb_next[k]  = (k == 0) ? in_sb : sb_reg[k-1];
            vld_next[k] = (k == 0) ? in_vld : vld_reg[k-1];
            sh    = {prev_rem[REMW-3:0], x_next[k][XW-1-2*k -: 2]};
            trial = REMW'({prev_root, 2'b01});
            if (sh >= trial)
            begin
                rem_next[k]  = sh - trial;
                root_next[k] = {prev_root[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = sh;
                root_next[k] = {prev_root[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RW; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < RW; k++)
                vld_reg[k] <= vld_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_next[k];
                sb_reg[k]   <= sb_next[k];
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_sb   = sb_reg[RW-1];
endmodule

### src/plda_div.sv
// pipelined restoring divider with saturation, one quotient bit per stage
module plda_div #(
    parameter int NUMW = 60,
    parameter int DENW = 63,
    parameter int SBW  = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [NUMW-1:0]               in_num,
    input  logic [DENW-1:0]               in_den,
    input  logic [SBW-1:0]                in_sb,
    output logic                          out_vld,
    output logic [plda_pkg::QUOT_W-1:0]   out_q,
    output logic                          out_sat,
    output logic [SBW-1:0]                out_sb
);
    localparam int QB  = plda_pkg::QUOT_W;
    localparam int NS  = QB + 1;
    localparam int DVW = (NUMW > DENW + QB) ? NUMW : DENW + QB;

    logic              vld_reg [NS];
    logic [DVW-1:0]    rem_reg [NS];
    logic [DENW-1:0]   den_reg [NS];
    logic [QB-1:0]     q_reg   [NS];
    logic              sat_reg [NS];
    logic [SBW-1:0]    sb_reg  [NS];

    logic              vld_next [NS];
    logic [DVW-1:0]    rem_next [NS];
    logic [DENW-1:0]   den_next [NS];
    logic [QB-1:0]     q_next   [NS];
    logic              sat_next [NS];
    logic [SBW-1:0]    sb_next  [NS];

    always_comb
    begin
        logic [DVW-1:0] dsh;
        for (int j = 0; j < NS; j++)
        begin
            if (j == 0)
            begin
                vld_next[j] = in_vld;
                den_next[j] = in_den;
                sb_next[j]  = in_sb;
                rem_next[j] = DVW'(in_num);
                q_next[j]   = '0;
                dsh         = DVW'(in_den) << QB;
                sat_next[j] = (DVW'(in_num) >= dsh);
            end
            else
            begin
                vld_next[j] = vld_reg[j-1];
                den_next[j] = den_reg[j-1];
                sb_next[j]  = sb_reg[j-1];
                sat_next[j] = sat_reg[j-1];
                q_next[j]   = q_reg[j-1];
                dsh         = DVW'(den_reg[j-1]) << (QB - j);
                if (rem_reg[j-1] >= dsh)
                begin
                    rem_next[j]        = rem_reg[j-1] - dsh;
                    q_next[j][QB - j]  = 1'b1;
                end
                else
                begin
                    rem_next[j] = rem_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NS; j++)
                vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            for (int j = 0; j < NS; j++)
                vld_reg[j] <= vld_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_next[j];
                q_reg[j]   <= q_next[j];
                sat_reg[j] <= sat_next[j];
                sb_reg[j]  <= sb_next[j];
            end
        end
    end

    assign out_vld = vld_reg[NS-1];
    assign out_q   = q_reg[NS-1];
    assign out_sat = sat_reg[NS-1];
    assign out_sb  = sb_reg[NS-1];
endmodule

### dv/plda_tb_if.sv
// testbench item and result types for the point light diffuse attenuation block
`timescale 1ns / 1ps
package plda_tb_types;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } vertex_item_t;

    typedef struct {
        logic [15:0] level;
        logic        beyond;
    } shade_t;

endpackage

### dv/tb_top.sv
// testbench top for the point light diffuse attenuation block
`timescale 1ns / 1ps
module tb_top;

    localparam int LATENCY   = 16 + 33;
    localparam int MAX_CYCLE = 2000000;
    localparam int HOLD_LEN  = 300;

    logic clk;
    logic rst_n;

    plda_cfg_if    cfg_ch ();
    plda_vertex_if #(.COORD_BITS(16), .NORMAL_BITS(16)) vtx_ch ();
    plda_level_if  lvl_ch ();

    point_light_diffuse_attenuate #(.COORD_BITS(16), .NORMAL_BITS(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .vertex (vtx_ch.sink),
        .level  (lvl_ch.source)
    );

    // shadow copy of the light registers
    logic signed [15:0] lpos_x, lpos_y, lpos_z;
    logic [15:0]        lstrength, lradius;

    plda_tb_types::vertex_item_t pending_vertices[$];
    plda_tb_types::shade_t       expected_shades[$];

    int error_count;
    int shades_seen;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int hold_cycles;
    bit vtx_hold;

    // restoring integer square root
    function automatic logic [63:0] root_of(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bit_v;
        res = 64'd0;
        bit_v = 64'd1 << 62;
        while (bit_v > x)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (x >= res + bit_v)
            begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // lambert term times strength over (1 + d^2), or zero out of reach
    function automatic plda_tb_types::shade_t shade_of(input plda_tb_types::vertex_item_t v);
        plda_tb_types::shade_t sh;
        logic signed [63:0] dx, dy, dz, dotn;
        logic [63:0] dist_sq, rad_sq, r, num, den, q;
        dx = 64'(lpos_x) - 64'(v.vx);
        dy = 64'(lpos_y) - 64'(v.vy);
        dz = 64'(lpos_z) - 64'(v.vz);
        dist_sq = dx * dx + dy * dy + dz * dz;
        dotn = 64'(v.nx) * dx + 64'(v.ny) * dy + 64'(v.nz) * dz;
        rad_sq = 64'(lradius) * 64'(lradius);
        sh.level = 0;
        sh.beyond = 0;
        if (dist_sq > rad_sq)
            sh.beyond = 1;
        else if (dist_sq != 0 && dotn > 0)
        begin
            r = root_of(dist_sq << 16);
            num = 64'(dotn) * 64'(lstrength) * 64'd1024;
            den = r * (64'd65536 + dist_sq);
            q = num / den;
            if (q > 64'(lstrength))
                q = 64'(lstrength);
            sh.level = q[15:0];
        end
        return sh;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s at result %0d: got %0d want %0d", what, shades_seen, got, want);
        error_count++;
    endtask

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top: errors");
            $finish;
        end
    end

    // long hold-off length, counted on its own
    always @(posedge clk)
    begin
        if (hold_off)
            hold_cycles <= hold_cycles + 1;
        else
            hold_cycles <= 0;
    end

    // vertex driver: present the head of the queue, keep it up while it waits
    always @(negedge clk)
    begin
        if (vtx_hold ||
            (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct))
        begin
            vtx_ch.valid    <= 1'b1;
            vtx_ch.vertex_x <= pending_vertices[0].vx;
            vtx_ch.vertex_y <= pending_vertices[0].vy;
            vtx_ch.vertex_z <= pending_vertices[0].vz;
            vtx_ch.normal_x <= pending_vertices[0].nx;
            vtx_ch.normal_y <= pending_vertices[0].ny;
            vtx_ch.normal_z <= pending_vertices[0].nz;
        end
        else
            vtx_ch.valid <= 1'b0;
        // receiver stall; a long hold-off overrides it
        if (hold_off)
            lvl_ch.ready <= 1'b0;
        else
            lvl_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predictor at the input: every accepted vertex transaction yields one shade
    always @(posedge clk)
    begin
        if (rst_n && vtx_ch.valid && vtx_ch.ready)
            expected_shades.push_back(shade_of(pending_vertices.pop_front()));
        vtx_hold <= rst_n && vtx_ch.valid && !vtx_ch.ready;
    end

    // monitor on the level channel
    always @(posedge clk)
    begin
        plda_tb_types::shade_t want;
        if (rst_n && lvl_ch.valid && lvl_ch.ready)
        begin
            if (expected_shades.size() == 0)
            begin
                report_mismatch("unexpected result", int'(lvl_ch.light_level), 0);
            end
            else
            begin
                want = expected_shades.pop_front();
                if (lvl_ch.light_level !== want.level)
                    report_mismatch("light_level", int'(lvl_ch.light_level),
                                    int'(want.level));
                if (lvl_ch.beyond_radius !== want.beyond)
                    report_mismatch("beyond_radius", int'(lvl_ch.beyond_radius),
                                    int'(want.beyond));
            end
            shades_seen++;
        end
    end

    task automatic write_reg(input plda_pkg::reg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            plda_pkg::REG_LIGHT_POS_X:    lpos_x = val;
            plda_pkg::REG_LIGHT_POS_Y:    lpos_y = val;
            plda_pkg::REG_LIGHT_POS_Z:    lpos_z = val;
            plda_pkg::REG_LIGHT_STRENGTH: lstrength = val;
            plda_pkg::REG_REACH_RADIUS:   lradius = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_light(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] pz, input logic [15:0] st,
                             input logic [15:0] rad);
        write_reg(plda_pkg::REG_LIGHT_POS_X, px);
        write_reg(plda_pkg::REG_LIGHT_POS_Y, py);
        write_reg(plda_pkg::REG_LIGHT_POS_Z, pz);
        write_reg(plda_pkg::REG_LIGHT_STRENGTH, st);
        write_reg(plda_pkg::REG_REACH_RADIUS, rad);
    endtask

    // wait for the pipeline to drain completely
    task automatic drain;
        while (pending_vertices.size() > 0 || expected_shades.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic add_vertex(input int vx, input int vy, input int vz,
                              input int nx, input int ny, input int nz);
        plda_tb_types::vertex_item_t v;
        v.vx = 16'(vx); v.vy = 16'(vy); v.vz = 16'(vz);
        v.nx = 16'(nx); v.ny = 16'(ny); v.nz = 16'(nz);
        pending_vertices.push_back(v);
    endtask

    function automatic int rand_normal_comp();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16384;
        if (sel == 1) return -16384;
        if (sel == 2) return 0;
        return $signed($urandom_range(32768)) - 16384;
    endfunction

    // vertices mostly near the light so that many land inside the radius
    task automatic add_random(input int spread);
        int j;
        int c[3];
        int lp[3];
        lp[0] = int'(lpos_x);
        lp[1] = int'(lpos_y);
        lp[2] = int'(lpos_z);
        for (j = 0; j < 3; j++)
        begin
            if ($urandom_range(9) == 0)
                c[j] = $signed($urandom_range(65535)) - 32768;
            else
                c[j] = lp[j] + $signed($urandom_range(2 * spread)) - spread;
            if (c[j] > 32767) c[j] = 32767;
            if (c[j] < -32768) c[j] = -32768;
        end
        add_vertex(c[0], c[1], c[2],
                   rand_normal_comp(), rand_normal_comp(), rand_normal_comp());
    endtask

    task automatic random_phase(input int count, input int idle, input int stall,
                                input int spread);
        int k;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (k = 0; k < count; k++)
            add_random(spread);
        drain();
    endtask

    initial
    begin
        error_count = 0;
        shades_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        rst_n = 0;
        cfg_ch.valid = 0;
        cfg_ch.addr = plda_pkg::REG_LIGHT_POS_X;
        cfg_ch.wdata = 0;
        vtx_ch.valid = 0;
        vtx_ch.vertex_x = 0; vtx_ch.vertex_y = 0; vtx_ch.vertex_z = 0;
        vtx_ch.normal_x = 0; vtx_ch.normal_y = 0; vtx_ch.normal_z = 0;
        lvl_ch.ready = 0;
        lpos_x = 0; lpos_y = 0; lpos_z = 0;
        lstrength = plda_pkg::STRENGTH_RESET;
        lradius = plda_pkg::RADIUS_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed, reset defaults: on the light, facing away, extremes, off-unit normals
        add_vertex(0, 0, 0, 16384, 0, 0);
        add_vertex(-256, 0, 0, 16384, 0, 0);
        add_vertex(-256, 0, 0, -16384, 0, 0);
        add_vertex(0, 256, 0, 0, 0, 16384);
        add_vertex(-32768, -32768, -32768, 16384, 16384, 16384);
        add_vertex(32767, 32767, 32767, -16384, -16384, -16384);
        add_vertex(-1, 0, 0, 16384, 16384, 16384);
        add_vertex(-16, -16, -16, 16384, 16384, 16384);
        add_vertex(0, 0, -1, -1, -1, -1);
        add_vertex(-32768, 0, 0, 16384, 0, 0);
        drain();

        // directed, radius cuts and extreme light positions
        set_light(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd512);
        add_vertex(32767, -32768, 32767, 16384, 0, 0);
        add_vertex(32767 - 512, -32768, 32767, 16384, 0, 0);
        add_vertex(32767 - 513, -32768, 32767, 16384, 0, 0);
        add_vertex(-32768, 32767, -32768, 16384, -16384, 16384);
        add_vertex(32767 - 300, -32768 + 300, 32767, 16384, -16384, 0);
        add_vertex(32767 - 5, -32768, 32767, 16384, 16384, 16384);
        drain();
        set_light(16'h8000, 16'h0000, 16'h0100, 16'd0, 16'd0);
        add_vertex(-32768, 0, 256, 16384, 0, 0);
        add_vertex(-32767, 0, 256, -16384, 0, 0);
        add_vertex(-32768, 0, 255, 0, 0, 16384);
        drain();

        // random phases over several light settings and idling mixes
        set_light(16'h0000, 16'h0000, 16'h0000, 16'd256, 16'hFFFF);
        random_phase(250, 0, 0, 1024);
        set_light(16'h0100, 16'h0100, 16'h0100, 16'd1000, 16'd2048);
        random_phase(250, 82, 0, 1500);
        set_light(16'hFF00, 16'h0040, 16'h0300, 16'hFFFF, 16'd300);
        random_phase(250, 0, 82, 400);
        set_light(16'h0010, 16'hFFF0, 16'h0000, 16'd4096, 16'd16);
        random_phase(250, 14, 14, 24);

        // long receiver hold-off while the sender keeps offering
        set_light(16'h0000, 16'h0000, 16'h0000, 16'd700, 16'd4000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1;
        for (int k = 0; k < 200; k++)
            add_random(2000);
        wait (hold_cycles >= HOLD_LEN);
        hold_off = 0;
        drain();

        // mixed idling until the stream runs out
        for (int k = 0; k < 6; k++)
        begin
            set_light(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)));
            random_phase(60, $urandom_range(1) ? 0 : 82, $urandom_range(1) ? 0 : 82,
                         1 << $urandom_range(12));
        end

        $display("covered %0d shaded vertices over reset, directed and random light settings",
                 shades_seen);
        $display("including idle, stall, long hold-off and radius edge cases");
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
